/* design/iaw_pkg.sv */
package iaw_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // register indexes
  localparam cfg_idx_t CFG_DIFF_THRESHOLD = 2'd0;
  localparam cfg_idx_t CFG_BOUNCE_LIMIT   = 2'd1;
  localparam cfg_idx_t CFG_TIMEOUT_MS     = 2'd2;
  localparam cfg_idx_t CFG_CHECK_INTERVAL = 2'd3;

  // reset values
  localparam logic [15:0] DIFF_THRESHOLD_RST = 16'd20;
  localparam logic [15:0] BOUNCE_LIMIT_RST   = 16'd1000;
  localparam logic [31:0] TIMEOUT_MS_RST     = 32'd10000;
  localparam logic [7:0]  CHECK_INTERVAL_RST = 8'd2;

  typedef struct packed {
    logic [15:0] diff_threshold;
    logic [15:0] bounce_limit;
    logic [31:0] timeout_ms;
    logic [7:0]  check_interval;
  } cfg_t;

  typedef struct packed {
    logic [15:0] distance;
    logic        presence;
    logic        alarm_request;
    logic        stop_request;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic alarm;
    logic message_pulse;
  } out_t;

endpackage

/* design/iaw_if.sv */
interface iaw_in_if;
  logic         valid;
  logic         ready;
  iaw_pkg::in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface iaw_out_if;
  logic          valid;
  logic          ready;
  iaw_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* design/iaw_cfg_regs.sv */
module iaw_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                we_i,
  input  iaw_pkg::cfg_idx_t                   idx_i,
  input  logic [iaw_pkg::CFG_DATA_W-1:0]      wdata_i,
  output iaw_pkg::cfg_t                       cfg_o
);
  import iaw_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      unique case (idx_i)
        CFG_DIFF_THRESHOLD: cfg_d.diff_threshold = wdata_i[15:0];
        CFG_BOUNCE_LIMIT:   cfg_d.bounce_limit   = wdata_i[15:0];
        CFG_TIMEOUT_MS:     cfg_d.timeout_ms     = wdata_i[31:0];
        CFG_CHECK_INTERVAL: cfg_d.check_interval = wdata_i[7:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.diff_threshold <= DIFF_THRESHOLD_RST;
      cfg_q.bounce_limit   <= BOUNCE_LIMIT_RST;
      cfg_q.timeout_ms     <= TIMEOUT_MS_RST;
      cfg_q.check_interval <= CHECK_INTERVAL_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* design/iaw_core.sv */
module iaw_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  iaw_pkg::cfg_t  cfg_i,
  input  logic           step_i,
  input  iaw_pkg::in_t   item_i,
  output iaw_pkg::out_t  res_o
);
  import iaw_pkg::*;

  logic        alarm_q, alarm_d;
  logic        first_q, first_d;
  logic        rp_q, rp_d;
  logic [7:0]  tick_q, tick_d;
  logic [15:0] last_q, last_d;
  logic [31:0] start_q, start_d;

  logic        monitor, check, moved, restart, timeout_hit, pulse;
  logic [15:0] delta;
  logic [31:0] elapsed;

  assign monitor = !alarm_q && first_q;
  assign check   = monitor && (tick_q == cfg_i.check_interval);
  assign delta   = (item_i.distance >= last_q) ? (item_i.distance - last_q)
                                               : (last_q - item_i.distance);
  assign moved   = (delta > cfg_i.diff_threshold) && (delta < cfg_i.bounce_limit);
  assign restart = moved || !item_i.presence || rp_q;
  assign elapsed = item_i.now_ms - start_q;
  assign timeout_hit = elapsed > cfg_i.timeout_ms;

  always_comb begin
    alarm_d = alarm_q;
    first_d = first_q;
    rp_d    = rp_q;
    tick_d  = tick_q;
    last_d  = last_q;
    start_d = start_q;
    pulse   = 1'b0;
    if (monitor) begin
      tick_d = check ? 8'd0 : tick_q + 8'd1;
      if (check) begin
        last_d = item_i.distance;
        if (restart) begin
          start_d = item_i.now_ms;
          rp_d    = 1'b0;
        end else if (timeout_hit) begin
          alarm_d = 1'b1;
          first_d = 1'b0;
          rp_d    = 1'b1;
          pulse   = 1'b1;
        end
      end
      if (item_i.alarm_request) begin
        alarm_d = 1'b1;
        rp_d    = 1'b1;
      end
    end else begin
      if (first_q) begin
        first_d = 1'b0;
        pulse   = 1'b1;
      end
      if (item_i.stop_request) begin
        alarm_d = 1'b0;
        first_d = 1'b1;
        rp_d    = 1'b1;
      end
    end
  end

  assign res_o.alarm         = alarm_d;
  assign res_o.message_pulse = pulse;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alarm_q <= 1'b0;
      first_q <= 1'b1;
      rp_q    <= 1'b1;
      tick_q  <= 8'd0;
      last_q  <= 16'd0;
      start_q <= 32'd0;
    end else if (step_i) begin
      alarm_q <= alarm_d;
      first_q <= first_d;
      rp_q    <= rp_d;
      tick_q  <= tick_d;
      last_q  <= last_d;
      start_q <= start_d;
    end
  end

  // a message is issued once per alarm episode; a stop on the pulse tick rearms
  a_pulse_clears_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && pulse && !item_i.stop_request |=> !first_q)
    else $error("message pulse left first_alarm set");

  // stop outside monitoring drops the alarm and rearms monitoring
  a_stop_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !monitor && item_i.stop_request |=> !alarm_q && first_q && rp_q)
    else $error("stop request did not rearm");

  // manual request latches the alarm with a pending restart
  a_request_latches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && monitor && item_i.alarm_request |=> alarm_q && rp_q)
    else $error("manual request did not latch alarm");

  // no pulse while staying in monitoring without a timeout
  a_pulse_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && monitor && !check |-> !pulse)
    else $error("pulse without a check");

endmodule

/* design/inactivity_alarm_watchdog.sv */
// Inactivity alarm watchdog. One input transfer is one task tick and yields
// exactly one result transfer: the alarm latch after the tick and a one-tick
// message pulse when the warning is issued. Ticks pass through an input
// register and a result register with the watchdog state updated in between,
// so a tick is accepted every cycle while the result side takes transfers;
// its result is offered from the result register once it has passed both
// registers. Throughput is one tick per cycle, limited only by the result
// side taking transfers. Configuration is a plain write port
// (index 0 diff_threshold, 1 bounce_limit, 2 timeout_ms, 3 check_interval)
// and must be written only while no tick is in flight.
module inactivity_alarm_watchdog (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  iaw_pkg::cfg_idx_t               cfg_idx_i,
  input  logic [iaw_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  iaw_in_if.sink                          in_i,
  iaw_out_if.source                       out_o
);
  import iaw_pkg::*;

  cfg_t cfg;

  // input stage
  logic in_valid_q;
  in_t  in_data_q;
  // result stage
  logic out_valid_q;
  out_t out_data_q;

  out_t res;
  logic advance;

  // tick moves into the result stage when that stage is empty or draining
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;

  iaw_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  iaw_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .step_i (advance),
    .item_i (in_data_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_data_q <= in_i.data;
    end
    if (advance) begin
      out_data_q <= res;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  // held result must not change while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q && $stable(out_data_q))
    else $error("stalled result changed");

  // a full input stage stays full until it moves on
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(in_data_q))
    else $error("input stage lost a tick");

  // every step fills the result stage
  a_step_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("step did not produce a result");

endmodule

/* tb/iaw_alarm_checker.sv */
// Watches the tick and result channels and the config port, models the
// watchdog and compares every result transfer with the oldest prediction.
module iaw_alarm_checker
  import iaw_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  cfg_idx_t              cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  iaw_in_if                     tick_mon_i,
  iaw_out_if                    result_mon_i,
  output int unsigned           mismatch_cnt_o,
  output int unsigned           pending_o
);

  cfg_t        cfg;
  logic        alarm_on;
  logic        first_alarm;
  logic        restart_pend;
  logic [7:0]  tick_cnt;
  logic [15:0] prev_dist;
  logic [31:0] timer_start;
  out_t        expected_q[$];

  // Advances the watchdog model by one tick and returns its result.
  function automatic out_t advance_watchdog(input in_t t);
    logic [15:0] delta;
    logic        moved;
    out_t        r;
    r.message_pulse = 1'b0;
    if (!alarm_on && first_alarm) begin
      if (tick_cnt == cfg.check_interval) begin
        tick_cnt = '0;
        delta = (t.distance >= prev_dist) ? t.distance - prev_dist
                                          : prev_dist - t.distance;
        prev_dist = t.distance;
        moved = (delta > cfg.diff_threshold) && (delta < cfg.bounce_limit);
        if (moved || !t.presence || restart_pend) begin
          timer_start  = t.now_ms;
          restart_pend = 1'b0;
        end else if (32'(t.now_ms - timer_start) > cfg.timeout_ms) begin
          alarm_on        = 1'b1;
          first_alarm     = 1'b0;
          restart_pend    = 1'b1;
          r.message_pulse = 1'b1;
        end
      end else begin
        tick_cnt = tick_cnt + 8'd1;
      end
      if (t.alarm_request) begin
        alarm_on     = 1'b1;
        restart_pend = 1'b1;
      end
    end else begin
      if (first_alarm) begin
        first_alarm     = 1'b0;
        r.message_pulse = 1'b1;
      end
      if (t.stop_request) begin
        alarm_on     = 1'b0;
        first_alarm  = 1'b1;
        restart_pend = 1'b1;
      end
    end
    r.alarm = alarm_on;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    out_t got;
    if (!rst_ni) begin
      cfg.diff_threshold = DIFF_THRESHOLD_RST;
      cfg.bounce_limit   = BOUNCE_LIMIT_RST;
      cfg.timeout_ms     = TIMEOUT_MS_RST;
      cfg.check_interval = CHECK_INTERVAL_RST;
      alarm_on       = 1'b0;
      first_alarm    = 1'b1;
      restart_pend   = 1'b1;
      tick_cnt       = '0;
      prev_dist      = '0;
      timer_start    = '0;
      mismatch_cnt_o = 0;
      expected_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_DIFF_THRESHOLD: cfg.diff_threshold = cfg_wdata_i[15:0];
          CFG_BOUNCE_LIMIT:   cfg.bounce_limit   = cfg_wdata_i[15:0];
          CFG_TIMEOUT_MS:     cfg.timeout_ms     = cfg_wdata_i[31:0];
          CFG_CHECK_INTERVAL: cfg.check_interval = cfg_wdata_i[7:0];
          default: ;
        endcase
      end
      if (result_mon_i.valid && result_mon_i.ready) begin
        got = result_mon_i.data;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result transfer, alarm %b pulse %b",
                   $time, got.alarm, got.message_pulse);
          mismatch_cnt_o++;
        end else begin
          want = expected_q.pop_front();
          if (got.alarm !== want.alarm) begin
            $display("%0t: alarm expected %b actual %b", $time, want.alarm, got.alarm);
            mismatch_cnt_o++;
          end
          if (got.message_pulse !== want.message_pulse) begin
            $display("%0t: message_pulse expected %b actual %b",
                     $time, want.message_pulse, got.message_pulse);
            mismatch_cnt_o++;
          end
        end
      end
      if (tick_mon_i.valid && tick_mon_i.ready) begin
        expected_q.push_back(advance_watchdog(tick_mon_i.data));
      end
    end
    pending_o = expected_q.size();
  end

endmodule

/* tb/tb_inactivity_alarm_watchdog.sv */
// Stimulus and verdict for the inactivity alarm watchdog. Prediction and
// comparison live in iaw_alarm_checker, which sits beside the DUT.
module tb_inactivity_alarm_watchdog;
  import iaw_pkg::*;

  localparam int unsigned NUM_PHASES      = 6;
  localparam int unsigned TICKS_PER_PHASE = 150;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  cfg_idx_t              cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  iaw_in_if  tick_if ();
  iaw_out_if result_if ();

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;

  // Idle percentages of sender and receiver for the current phase.
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;

  // Config currently loaded, plus running distance and clock used to build
  // plausible tick sequences.
  cfg_t        cur_cfg;
  logic [15:0] last_dist;
  logic [31:0] clock_ms;

  inactivity_alarm_watchdog DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (tick_if),
    .out_o       (result_if)
  );

  iaw_alarm_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .tick_mon_i     (tick_if),
    .result_mon_i   (result_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop in case a transfer never completes.
  initial begin
    #5_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: ready is redrawn every cycle, one NBA per edge.
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      result_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Offers one tick and returns at the edge where it transfers. Valid is
  // left high so back-to-back ticks never see a low/high pair in one step;
  // it is lowered only when a gap is taken.
  task automatic send_tick(input in_t t);
    if ($urandom_range(99) < src_idle_pct) begin
      tick_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    tick_if.valid <= 1'b1;
    tick_if.data  <= t;
    do @(posedge clk_i); while (!tick_if.ready);
  endtask

  task automatic tick(input logic [15:0] sample, input logic pres, input logic req,
                      input logic stop, input logic [31:0] now);
    in_t t;
    t.distance      = sample;
    t.presence      = pres;
    t.alarm_request = req;
    t.stop_request  = stop;
    t.now_ms        = now;
    send_tick(t);
  endtask

  // Drops valid and waits until every predicted result has transferred.
  // The first edge lets the checker register a tick taken at the last edge.
  task automatic drain();
    tick_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
  endtask

  // Writes all four registers on consecutive edges; the enable stays high
  // throughout and drops once at the end.
  task automatic load_config(input cfg_t c);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= CFG_DIFF_THRESHOLD;
    cfg_wdata_i <= CFG_DATA_W'(c.diff_threshold);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_BOUNCE_LIMIT;
    cfg_wdata_i <= CFG_DATA_W'(c.bounce_limit);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_TIMEOUT_MS;
    cfg_wdata_i <= CFG_DATA_W'(c.timeout_ms);
    @(posedge clk_i);
    cfg_idx_i   <= CFG_CHECK_INTERVAL;
    cfg_wdata_i <= CFG_DATA_W'(c.check_interval);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cur_cfg = c;
  endtask

  // Builds one random tick. Clock steps are scaled so that a still person
  // reaches the timeout after a few checks; distances mostly stay still,
  // sometimes move, sometimes glitch, and now and then jump anywhere.
  function automatic in_t make_tick();
    in_t             t;
    longint unsigned span;
    int unsigned     thr;
    int unsigned     bnc;
    int unsigned     delta;
    int unsigned     pick;
    int              cur;
    int              nxt;
    thr  = 32'(cur_cfg.diff_threshold);
    bnc  = 32'(cur_cfg.bounce_limit);
    span = (64'(cur_cfg.timeout_ms) + 64'd4) / (64'(cur_cfg.check_interval) + 64'd1)
           / 64'd2;
    if (span > 64'h4000_0000) span = 64'h4000_0000;

    pick = $urandom_range(99);
    if (pick < 3) clock_ms = $urandom;                // jump anywhere
    else if (pick < 7) clock_ms = clock_ms + $urandom; // big step, often wraps
    else clock_ms = clock_ms + $urandom_range(32'(span), 0);

    pick = $urandom_range(99);
    cur  = int'(last_dist);
    if (pick < 70) delta = $urandom_range(thr / 4, 0);
    else if (pick < 85 && bnc > thr + 1) delta = $urandom_range(bnc - 1, thr + 1);
    else delta = $urandom_range(65535, bnc);
    if (pick >= 93) nxt = $urandom_range(65535, 0);
    else if (cur + int'(delta) <= 65535 && (cur < int'(delta) || $urandom_range(1, 0) == 1))
      nxt = cur + int'(delta);
    else nxt = cur - int'(delta);

    t.distance      = 16'(nxt);
    t.presence      = ($urandom_range(99) < 92);
    t.alarm_request = ($urandom_range(99) < 2);
    t.stop_request  = ($urandom_range(99) < 12);
    t.now_ms        = clock_ms;
    last_dist       = t.distance;
    return t;
  endfunction

  initial begin
    // field order: diff_threshold, bounce_limit, timeout_ms, check_interval
    cfg_t plan [NUM_PHASES];
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = CFG_DIFF_THRESHOLD;
    cfg_wdata_i    = '0;
    tick_if.valid  = 1'b0;
    tick_if.data   = '0;
    src_idle_pct   = 28;
    snk_idle_pct   = 86;
    last_dist      = '0;
    clock_ms       = '0;
    cur_cfg        = '{DIFF_THRESHOLD_RST, BOUNCE_LIMIT_RST, TIMEOUT_MS_RST,
                       CHECK_INTERVAL_RST};

    plan[0] = '{16'd20, 16'd1000, 32'd10000, 8'd2};
    // nothing counts as movement, timeout unreachable, checks rarely
    plan[1] = '{16'hFFFF, 16'h0000, 32'hFFFF_FFFF, 8'hFF};
    // interval drops below the count left by the previous phase: counter wraps
    plan[2] = '{16'd5, 16'd300, 32'd50, 8'd1};
    // any change short of 0xFFFF moves, any elapsed time trips, every tick is a check
    plan[3] = '{16'h0000, 16'hFFFF, 32'd0, 8'd0};
    plan[4] = '{16'($urandom_range(200)), 16'($urandom_range(3000)),
                32'($urandom_range(5000)), 8'($urandom_range(6))};
    plan[5] = '{16'($urandom), 16'($urandom), 32'($urandom_range(20000)),
                8'($urandom_range(15))};

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed ticks: default limits but every tick is a check, so each
    // case lands on a check without filler ticks.
    load_config('{16'd20, 16'd1000, 32'd10000, 8'd0});
    tick(16'hFFFF, 1'b1, 1'b0, 1'b1, 32'hFFFF_FF00); // restart pending; stop ignored while watching
    tick(16'hFFEB, 1'b1, 1'b0, 1'b0, 32'h0000_2610); // change equals threshold; elapsed = timeout
    tick(16'hFFEB, 1'b1, 1'b0, 1'b0, 32'h0000_2611); // one past timeout: alarm and pulse together
    tick(16'h0000, 1'b1, 1'b0, 1'b0, 32'h0000_0000); // alarm held, no second pulse
    tick(16'h0000, 1'b1, 1'b1, 1'b1, 32'h0000_0000); // stop clears; request ignored during alarm
    tick(16'h0000, 1'b1, 1'b0, 1'b0, 32'd100);       // restart after stop
    tick(16'd21,   1'b1, 1'b0, 1'b0, 32'd20000);     // just above threshold: movement
    tick(16'd1021, 1'b1, 1'b0, 1'b0, 32'd25000);     // change equals bounce limit: glitch
    tick(16'd2020, 1'b1, 1'b0, 1'b0, 32'd29000);     // just below bounce limit: movement
    tick(16'd2020, 1'b0, 1'b0, 1'b0, 32'd60000);     // absence restarts timer
    tick(16'd2020, 1'b1, 1'b1, 1'b0, 32'd60001);     // manual alarm, pulse comes next tick
    tick(16'd2020, 1'b1, 1'b0, 1'b0, 32'd60002);
    tick(16'd2020, 1'b1, 1'b0, 1'b1, 32'd60003);
    tick(16'd2020, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF); // restart at top of clock range
    tick(16'd2020, 1'b1, 1'b0, 1'b0, 32'h0000_0000); // elapsed of one across wrap
    tick(16'h0000, 1'b1, 1'b0, 1'b0, 32'd5);         // large drop above bounce limit
    tick(16'h0000, 1'b1, 1'b1, 1'b1, 32'd10);        // request and stop together while watching
    tick(16'h0000, 1'b1, 1'b0, 1'b1, 32'd11);        // pulse and stop on the same tick
    drain();

    // Random phases: sender mostly busy / receiver stalling, then swapped,
    // then neither idles.
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p == 2) begin
        src_idle_pct = 86;
        snk_idle_pct = 28;
      end else if (p == 4) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      load_config(plan[p]);
      repeat (TICKS_PER_PHASE) send_tick(make_tick());
      drain();
    end

    // leave a margin for stray result transfers
    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* inactivity_alarm_watchdog.f */
design/iaw_pkg.sv
design/iaw_if.sv
design/iaw_cfg_regs.sv
design/iaw_core.sv
design/inactivity_alarm_watchdog.sv
tb/iaw_alarm_checker.sv
tb/tb_inactivity_alarm_watchdog.sv
